// File: design/stepper_pulse_controller_top_defines.svh
// ----------------------------------------------------------------------------
// stepper_pulse_controller_top_defines
// Assertion macros for the stepper pulse controller.
// ----------------------------------------------------------------------------
`ifndef STEPPER_PULSE_CONTROLLER_TOP_DEFINES_SVH
`define STEPPER_PULSE_CONTROLLER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define SPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: design/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the stepper pulse controller.
// ----------------------------------------------------------------------------
`default_nettype none
package spc_pkg;
  localparam int POS_WIDTH_DEF = 32;
  localparam logic [2:0] FUNC_TICK = 3'd0;
  localparam logic [2:0] FUNC_VEL  = 3'd1;
  localparam logic [2:0] FUNC_MOVE = 3'd2;
  localparam logic [2:0] FUNC_HOME = 3'd3;
  localparam logic [2:0] FUNC_RAMP = 3'd4;
  localparam logic [1:0] REG_CLOCK = 2'd0;
  localparam logic [1:0] REG_START = 2'd1;
  localparam logic [1:0] REG_HOME  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // register the input item for decode
    logic div_start; // start clock_hz / rate
    logic sqrt_start;
    logic finish;    // apply period and run one generator clock, show result
  } spc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_freq; // command requires a new period
    logic div_done;
    logic sqrt_done;
  } spc_stat_t;
endpackage
`default_nettype wire

// File: design/spc_ctrl.sv
// ----------------------------------------------------------------------------
// spc_ctrl
// Sequencer for command acceptance, divide, root and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module spc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              out_free,
  input  wire spc_pkg::spc_stat_t stat,
  output logic                   in_ready,
  output spc_pkg::spc_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.need_freq) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: if (stat.sqrt_done) state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// File: design/spc_datapath.sv
// ----------------------------------------------------------------------------
// spc_datapath
// Motion state, serial divider, serial square root and pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none
module spc_datapath #(
  parameter int POS_WIDTH = spc_pkg::POS_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spc_pkg::spc_cmd_t  cmd,
  output spc_pkg::spc_stat_t      stat,
  input  wire logic [2:0]         func,
  input  wire logic [31:0]        value,
  input  wire logic [31:0]        ramp_inc,
  input  wire logic [31:0]        ramp_limit,
  input  wire logic [31:0]        clock_hz,
  input  wire logic [31:0]        start_rate,
  input  wire logic [31:0]        home_offset,
  output logic [69:0]             result
);
  logic run_r, auto_r, zero_r, rev_r;
  logic [POS_WIDTH-1:0] pos_r, tpos_r;
  logic [31:0] tcnt_r, pulses_r, rate_r;
  logic [15:0] root_r, pre_r, per_r;
  logic [2:0]  func_r;
  logic [31:0] val_r, inc_r, lim_r;
  logic        need_r;
  logic [31:0] nrate_r;
  logic        need_c;
  logic [31:0] nrate_c;

  // Command decode on registered item, evaluated in the decode cycle.
  logic [POS_WIDTH-1:0] tgt, diff, dmag, pos_h;
  logic dneg, hneg, vneg;
  logic [31:0] vmag, hmag, rsum;
  logic [32:0] rsum_w;
  assign tgt  = POS_WIDTH'($signed(val_r));
  assign vneg = val_r[31];
  assign vmag = vneg ? (32'd0 - val_r) : val_r;
  assign hneg = home_offset[31];
  assign hmag = hneg ? (32'd0 - home_offset) : home_offset;
  assign rsum_w = {1'b0, rate_r} + {1'b0, inc_r};
  assign rsum = rsum_w[32] ? 32'hFFFFFFFF : rsum_w[31:0];

  // Position after the implicit halt of the generator.
  assign pos_h = rev_r ? (pos_r - POS_WIDTH'(pulses_r)) : (pos_r + POS_WIDTH'(pulses_r));
  logic halt_pre;
  assign halt_pre = (run_r || auto_r);
  logic [POS_WIDTH-1:0] pos_m;
  assign pos_m = halt_pre ? pos_h : pos_r;
  assign diff = tgt - pos_m;
  assign dneg = diff[POS_WIDTH-1];
  assign dmag = dneg ? (POS_WIDTH'(0) - diff) : diff;

  // Serial restoring divider.
  logic [31:0] q_r, rem_r, dvs_r;
  logic [5:0]  dcnt_r;
  logic        dbusy_r, dzero_r;
  logic [32:0] rtry;
  assign rtry = {rem_r, q_r[31]} - {1'b0, dvs_r};

  // Serial root, two bits per step.
  logic [31:0] sv_r, sres_r, sbit_r;
  logic        sbusy_r;
  logic [31:0] sadd;
  assign sadd = sres_r + sbit_r;

  assign stat.need_freq = need_c;
  assign stat.div_done  = dbusy_r && (dcnt_r == 6'd0);
  assign stat.sqrt_done = sbusy_r && (sbit_r == 32'd0);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_r <= clock_hz; rem_r <= '0; dvs_r <= nrate_c;
      dzero_r <= (nrate_c == 32'd0); dcnt_r <= 6'd32;
    end else if (dbusy_r && dcnt_r != 6'd0) begin
      dcnt_r <= dcnt_r - 6'd1;
      if (!rtry[32]) begin
        rem_r <= rtry[31:0]; q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], q_r[31]}; q_r <= {q_r[30:0], 1'b0};
      end
    end
    if (cmd.sqrt_start) begin
      sv_r <= dzero_r ? 32'hFFFFFFFF : q_r; sres_r <= '0; sbit_r <= 32'h40000000;
    end else if (sbusy_r && sbit_r != 32'd0) begin
      if (sv_r >= sadd) begin
        sv_r <= sv_r - sadd; sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0; sbusy_r <= 1'b0;
    end else begin
      if (cmd.div_start) dbusy_r <= 1'b1;
      else if (cmd.sqrt_start) dbusy_r <= 1'b0;
      if (cmd.sqrt_start) sbusy_r <= 1'b1;
      else if (cmd.finish) sbusy_r <= 1'b0;
    end
  end

  // Decode cycle: whether a new rate is needed and which one.
  always_comb begin
    need_c = 1'b0;
    nrate_c = rate_r;
    case (func_r)
      spc_pkg::FUNC_VEL:  if (val_r != 32'd0 && rate_r != vmag) begin
        need_c = 1'b1; nrate_c = vmag;
      end
      spc_pkg::FUNC_MOVE: if (pos_m != tgt) begin
        need_c = 1'b1; nrate_c = start_rate;
      end
      spc_pkg::FUNC_HOME: if (!zero_r) begin
        need_c = 1'b1; nrate_c = start_rate;
      end
      spc_pkg::FUNC_RAMP: if (auto_r && pulses_r < lim_r) begin
        need_c = 1'b1; nrate_c = rsum;
      end
      default: need_c = 1'b0;
    endcase
  end

  logic phase_r; // high in the cycle after load
  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= 1'b0;
    else phase_r <= cmd.load;
  end
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func; val_r <= value; inc_r <= ramp_inc; lim_r <= ramp_limit;
    end
    if (phase_r) begin
      need_r <= need_c; nrate_r <= nrate_c;
    end
  end
  // The decision is kept for the finish step, since motion state holds until then.

  // Finish: apply command, then one generator clock.
  logic c_run, c_auto, c_zero, c_rev, c_done, lvl;
  logic [POS_WIDTH-1:0] c_pos, c_tpos;
  logic [31:0] c_tcnt, c_pul, c_rate;
  logic [15:0] c_root, c_pre, c_per, xh;
  logic [31:0] nroot;
  assign nroot = (sres_r == 32'd0) ? 32'd1 : {16'd0, sres_r[15:0]};

  always_comb begin
    c_run = run_r; c_auto = auto_r; c_zero = zero_r; c_rev = rev_r;
    c_pos = pos_r; c_tpos = tpos_r; c_tcnt = tcnt_r; c_pul = pulses_r;
    c_rate = rate_r; c_root = root_r; c_pre = pre_r; c_per = per_r;
    c_done = 1'b0; lvl = 1'b0;
    case (func_r)
      spc_pkg::FUNC_VEL: begin
        if (val_r == 32'd0) begin
          if (run_r) begin
            c_run = 1'b0; c_auto = 1'b0; c_pos = pos_h; c_pul = '0;
          end
        end else begin
          if (auto_r || zero_r) begin
            c_zero = 1'b0; c_auto = 1'b0; c_pos = pos_h; c_pul = '0;
          end
          c_rev = vneg;
          if (need_r) begin c_rate = nrate_r; c_root = nroot[15:0]; end
          if (!run_r) begin c_run = 1'b1; c_pre = '0; c_per = '0; end
        end
      end
      spc_pkg::FUNC_MOVE: begin
        if (halt_pre) begin
          c_run = 1'b0; c_auto = 1'b0; c_pos = pos_h; c_pul = '0;
        end
        if (need_r) begin
          c_tpos = tgt; c_rev = dneg; c_rate = nrate_r; c_root = nroot[15:0];
          c_auto = 1'b1; c_pul = '0; c_tcnt = 32'(dmag); c_pre = '0; c_per = '0;
        end
      end
      spc_pkg::FUNC_HOME: begin
        if (run_r) begin
          c_run = 1'b0; c_auto = 1'b0; c_pos = pos_h; c_pul = '0;
        end
        if (need_r) begin
          c_zero = 1'b1; c_rev = hneg; c_rate = nrate_r; c_root = nroot[15:0];
          c_auto = 1'b1; c_pul = '0; c_tcnt = hmag; c_pre = '0; c_per = '0;
        end
      end
      spc_pkg::FUNC_RAMP: if (need_r) begin c_rate = nrate_r; c_root = nroot[15:0]; end
      default: c_done = 1'b0;
    endcase
    // First match check.
    if (c_auto && c_pul == c_tcnt) begin
      c_auto = 1'b0;
      c_pos = c_rev ? (c_pos - POS_WIDTH'(c_pul)) : (c_pos + POS_WIDTH'(c_pul));
      c_pul = '0;
      if (c_zero) begin c_zero = 1'b0; c_pos = '0; c_tpos = '0; end
      c_done = 1'b1;
    end
    if (c_run || c_auto) begin
      xh = c_root >> 1;
      lvl = c_per < xh;
      if (lvl && c_pre == 16'd0 && c_per == 16'd0) c_pul = c_pul + 32'd1;
      if ({16'd0, c_pre} + 32'd1 >= {16'd0, c_root}) begin
        c_pre = '0;
        c_per = ({16'd0, c_per} + 32'd1 >= {16'd0, c_root}) ? 16'd0 : c_per + 16'd1;
      end else begin
        c_pre = c_pre + 16'd1;
      end
      if (c_auto && c_pul == c_tcnt) begin
        c_auto = 1'b0;
        c_pos = c_rev ? (c_pos - POS_WIDTH'(c_pul)) : (c_pos + POS_WIDTH'(c_pul));
        c_pul = '0;
        if (c_zero) begin c_zero = 1'b0; c_pos = '0; c_tpos = '0; end
        c_done = 1'b1;
      end
    end else begin
      xh = '0;
    end
  end

  logic [31:0] pos32;
  assign pos32 = 32'($signed(c_pos));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; auto_r <= 1'b0; zero_r <= 1'b0; rev_r <= 1'b0;
      pos_r <= '0; tpos_r <= '0; tcnt_r <= '0; pulses_r <= '0; rate_r <= '0;
      root_r <= 16'd1; pre_r <= '0; per_r <= '0;
    end else if (cmd.finish) begin
      run_r <= c_run; auto_r <= c_auto; zero_r <= c_zero; rev_r <= c_rev;
      pos_r <= c_pos; tpos_r <= c_tpos; tcnt_r <= c_tcnt; pulses_r <= c_pul;
      rate_r <= c_rate; root_r <= c_root; pre_r <= c_pre; per_r <= c_per;
    end
  end

  // Result: step, dir, vel, move, homing, position, pulse_count, done.
  always_ff @(posedge clk) begin
    if (cmd.finish)
      result <= {c_done, c_pul, pos32, c_zero, c_auto, c_run, c_rev, lvl};
  end
endmodule
`default_nettype wire

// File: design/stepper_pulse_controller_top.sv
// Stepper pulse controller, top level.
// A tick or a command that keeps the period passes the decode and finish states before its result is registered.
// A command that sets a new rate also runs the serial divide and then the serial root first.
// One item is in flight at a time, so a new item is taken only after the last one has
// finished; a result held back by out_tready delays only the finish step.
// Reset (rst_n low, synchronous) stops the generator, clears position and counters,
// restores the register defaults and empties the output register.
`default_nettype none
`include "stepper_pulse_controller_top_defines.svh"
module stepper_pulse_controller_top #(
  parameter int POS_WIDTH = spc_pkg::POS_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: value[31:0], ramp_inc[63:32], ramp_limit[95:64]
  input  wire logic [95:0] in_tdata,
  // tuser: func[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: step_out[0], dir_out[1], velocity_active[2], move_active[3], homing[4],
  // position[36:5], pulse_count[68:37], move_done[69], zero fill up to 71
  output logic [71:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  // Configuration registers; a write lands in the access cycle.
  logic [31:0] clock_hz_r, start_rate_r, home_offset_r;
  logic        wr;
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= 32'd168000000; start_rate_r <= 32'd1000;
      home_offset_r <= 32'hFFFFB1E0;
    end else if (wr) begin
      case (cfg_paddr[3:2])
        spc_pkg::REG_CLOCK: clock_hz_r    <= cfg_pwdata;
        spc_pkg::REG_START: start_rate_r  <= cfg_pwdata;
        spc_pkg::REG_HOME:  home_offset_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      spc_pkg::REG_CLOCK: cfg_prdata = clock_hz_r;
      spc_pkg::REG_START: cfg_prdata = start_rate_r;
      spc_pkg::REG_HOME:  cfg_prdata = home_offset_r;
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // The output register parts the two sides: a new item is taken while the
  // previous result still waits, and only the finish step waits for it to leave.
  logic out_free, in_fire;
  spc_pkg::spc_cmd_t  cmd;
  spc_pkg::spc_stat_t stat;
  logic [69:0] result;
  assign out_free = !out_tvalid || out_tready;
  assign in_fire  = in_tvalid && in_tready;

  spc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .stat(stat), .in_ready(in_tready), .cmd(cmd)
  );

  spc_datapath #(.POS_WIDTH(POS_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .func(in_tuser), .value(in_tdata[31:0]), .ramp_inc(in_tdata[63:32]),
    .ramp_limit(in_tdata[95:64]), .clock_hz(clock_hz_r),
    .start_rate(start_rate_r), .home_offset(home_offset_r), .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (cmd.finish) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
  end
  assign out_tdata = {2'd0, result};

  // A new item is never taken while the datapath still works on one.
  `SPC_ASSERT_NXT(a_no_overlap, in_fire, !in_tready)
  // Finishing always leaves a valid result behind.
  `SPC_ASSERT_NXT(a_finish_valid, cmd.finish, out_tvalid)
  // The divider is never started together with the root or the finish step.
  `SPC_ASSERT_IMP(a_one_unit, cmd.div_start, !cmd.sqrt_start && !cmd.finish)
endmodule
`default_nettype wire
